>>> src/tqws_pkg.sv
// Shared types, constants and codes for the two-queue weighted server.
package tqws_pkg;

  localparam int Depth  = 64;
  localparam int AddrW  = $clog2(Depth);
  localparam int CountW = $clog2(Depth + 1);
  localparam int IdW    = 16;
  localparam int BurstW = 4;
  localparam int OutCntW = 7;
  localparam int ApbAw  = 3;
  localparam int ApbDw  = 32;

  localparam logic [BurstW-1:0] BurstReset = 4'd2;

  localparam logic REQ_PUSH  = 1'b0;
  localparam logic REQ_SERVE = 1'b1;

  localparam logic REG_A_BURST = 1'b0;

  typedef struct packed {
    logic           req_type;
    logic [IdW-1:0] customer_id;
  } in_t;

  typedef struct packed {
    logic               served_valid;
    logic [IdW-1:0]     served_id;
    logic               served_from_b;
    logic               push_dropped;
    logic [OutCntW-1:0] count_a;
    logic [OutCntW-1:0] count_b;
  } out_t;

  typedef struct packed {
    logic push_go;
    logic serve_go;
    logic serve_done;
  } cmd_t;

  typedef struct packed {
    logic is_serve;
  } stat_t;

endpackage

>>> src/tqws_ram.sv
// Generic single-write, single-read RAM with registered read data.
module tqws_ram #(
  parameter int Width = 16,
  parameter int Depth = 64
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(Depth)-1:0] waddr_i,
  input  logic [Width-1:0]         wdata_i,
  input  logic [$clog2(Depth)-1:0] raddr_i,
  output logic [Width-1:0]         rdata_o
);

  logic [Width-1:0] mem_q [Depth];
  logic [Width-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_q <= mem_q[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

>>> src/tqws_ctrl.sv
// Controller state machine: sequences push and serve transfers.
module tqws_ctrl (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             start_i,
  input  tqws_pkg::stat_t  stat_i,
  output tqws_pkg::cmd_t   cmd_o,
  output logic             busy_o
);

  localparam logic StIdle = 1'b0;
  localparam logic StRead = 1'b1;

  logic state_q, state_d;
  logic accept;

  assign accept = start_i && (state_q == StIdle);

  always_comb begin
    state_d          = state_q;
    cmd_o.push_go    = 1'b0;
    cmd_o.serve_go   = 1'b0;
    cmd_o.serve_done = 1'b0;
    case (state_q)
      StIdle: begin
        if (accept) begin
          if (stat_i.is_serve) begin
            cmd_o.serve_go = 1'b1;
            state_d        = StRead;
          end else begin
            cmd_o.push_go = 1'b1;
          end
        end
      end
      StRead: begin
        cmd_o.serve_done = 1'b1;
        state_d          = StIdle;
      end
      default: state_d = StIdle;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= StIdle;
    end else begin
      state_q <= state_d;
    end
  end

  assign busy_o = (state_q != StIdle);

endmodule

>>> src/tqws_dp.sv
// Datapath: queue pointers, fill counts, burst counter, id stores, result register.
module tqws_dp (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  tqws_pkg::in_t                 in_i,
  input  logic [tqws_pkg::BurstW-1:0]   a_burst_i,
  input  tqws_pkg::cmd_t                cmd_i,
  output tqws_pkg::stat_t               stat_o,
  output logic                          done_o,
  output tqws_pkg::out_t                res_o
);

  localparam int AW = tqws_pkg::AddrW;
  localparam int CW = tqws_pkg::CountW;
  localparam int BW = tqws_pkg::BurstW;

  logic [AW-1:0] head_a_q, head_a_d, tail_a_q, tail_a_d;
  logic [AW-1:0] head_b_q, head_b_d, tail_b_q, tail_b_d;
  logic [CW-1:0] fill_a_q, fill_a_d, fill_b_q, fill_b_d;
  logic [BW-1:0] burst_q, burst_d;
  logic          pick_valid_q, pick_valid_d, pick_b_q, pick_b_d;
  logic          done_q, done_d;
  tqws_pkg::out_t res_q, res_d;

  logic is_odd, full_a, full_b, we_a, we_b, pick_a, pick_b;
  logic [tqws_pkg::IdW-1:0] rdata_a, rdata_b;

  function automatic logic [AW-1:0] next_slot(input logic [AW-1:0] p);
    return (p == AW'(tqws_pkg::Depth - 1)) ? '0 : p + AW'(1);
  endfunction

  assign stat_o.is_serve = (in_i.req_type == tqws_pkg::REQ_SERVE);

  assign is_odd = in_i.customer_id[0];
  assign full_a = (fill_a_q == CW'(tqws_pkg::Depth));
  assign full_b = (fill_b_q == CW'(tqws_pkg::Depth));
  assign we_a   = cmd_i.push_go && is_odd && !full_a;
  assign we_b   = cmd_i.push_go && !is_odd && !full_b;

  always_comb begin
    pick_a  = 1'b0;
    pick_b  = 1'b0;
    burst_d = burst_q;
    if (cmd_i.serve_go) begin
      if (burst_q < a_burst_i) begin
        if (fill_a_q != '0) begin
          pick_a  = 1'b1;
          burst_d = burst_q + BW'(1);
        end else if (fill_b_q != '0) begin
          pick_b  = 1'b1;
          burst_d = '0;
        end
      end else begin
        if (fill_b_q != '0) begin
          pick_b  = 1'b1;
          burst_d = '0;
        end else if (fill_a_q != '0) begin
          pick_a  = 1'b1;
          burst_d = BW'(1);
        end
      end
    end
  end

  always_comb begin
    head_a_d = pick_a ? next_slot(head_a_q) : head_a_q;
    head_b_d = pick_b ? next_slot(head_b_q) : head_b_q;
    tail_a_d = we_a ? next_slot(tail_a_q) : tail_a_q;
    tail_b_d = we_b ? next_slot(tail_b_q) : tail_b_q;
    fill_a_d = fill_a_q + CW'(we_a) - CW'(pick_a);
    fill_b_d = fill_b_q + CW'(we_b) - CW'(pick_b);
    pick_valid_d = cmd_i.serve_go ? (pick_a || pick_b) : pick_valid_q;
    pick_b_d     = cmd_i.serve_go ? pick_b : pick_b_q;
  end

  always_comb begin
    res_d  = res_q;
    done_d = 1'b0;
    if (cmd_i.push_go) begin
      done_d              = 1'b1;
      res_d.served_valid  = 1'b0;
      res_d.served_id     = '0;
      res_d.served_from_b = 1'b0;
      res_d.push_dropped  = is_odd ? full_a : full_b;
      res_d.count_a       = tqws_pkg::OutCntW'(fill_a_d);
      res_d.count_b       = tqws_pkg::OutCntW'(fill_b_d);
    end else if (cmd_i.serve_done) begin
      done_d              = 1'b1;
      res_d.served_valid  = pick_valid_q;
      res_d.served_from_b = pick_valid_q && pick_b_q;
      res_d.push_dropped  = 1'b0;
      res_d.count_a       = tqws_pkg::OutCntW'(fill_a_q);
      res_d.count_b       = tqws_pkg::OutCntW'(fill_b_q);
      if (!pick_valid_q) begin
        res_d.served_id = '0;
      end else if (pick_b_q) begin
        res_d.served_id = rdata_b;
      end else begin
        res_d.served_id = rdata_a;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      head_a_q     <= '0;
      tail_a_q     <= '0;
      fill_a_q     <= '0;
      head_b_q     <= '0;
      tail_b_q     <= '0;
      fill_b_q     <= '0;
      burst_q      <= '0;
      pick_valid_q <= 1'b0;
      pick_b_q     <= 1'b0;
      done_q       <= 1'b0;
    end else begin
      head_a_q     <= head_a_d;
      tail_a_q     <= tail_a_d;
      fill_a_q     <= fill_a_d;
      head_b_q     <= head_b_d;
      tail_b_q     <= tail_b_d;
      fill_b_q     <= fill_b_d;
      burst_q      <= burst_d;
      pick_valid_q <= pick_valid_d;
      pick_b_q     <= pick_b_d;
      done_q       <= done_d;
    end
  end

  always_ff @(posedge clk_i) begin
    res_q <= res_d;
  end

  // read data lands the cycle after the serve transfer, from the old head
  tqws_ram #(
    .Width (tqws_pkg::IdW),
    .Depth (tqws_pkg::Depth)
  ) u_store_a (
    .clk_i   (clk_i),
    .we_i    (we_a),
    .waddr_i (tail_a_q),
    .wdata_i (in_i.customer_id),
    .raddr_i (head_a_q),
    .rdata_o (rdata_a)
  );

  tqws_ram #(
    .Width (tqws_pkg::IdW),
    .Depth (tqws_pkg::Depth)
  ) u_store_b (
    .clk_i   (clk_i),
    .we_i    (we_b),
    .waddr_i (tail_b_q),
    .wdata_i (in_i.customer_id),
    .raddr_i (head_b_q),
    .rdata_o (rdata_b)
  );

  assign done_o = done_q;
  assign res_o  = res_q;

endmodule

>>> src/two_queue_weighted_server.sv
// Top level of the two-queue weighted server: APB register, controller, datapath.
//
// Usage:
//   Requests enter on req_i with start; a transfer happens at a clock edge
//   where start is high and busy is low. A push (req_type 0) files the id in
//   queue A (odd) or queue B (even); a serve (req_type 1) takes the next id
//   under the weighted rule: up to a_burst ids from A, then one from B.
//   Each request gives one result on res_o, marked by done_o for one cycle.
//   A push result shows in the cycle after its transfer; a serve result
//   comes after the StRead state, since the id comes out of a registered-read store.
//   Throughput: one push per cycle; a serve holds busy through the StRead
//   state, so no request transfers until it is left. The new request may transfer while the
//   previous result is on res_o.
//   The receiver cannot stall; results must be taken when done_o is high.
//   Reset empties both queues, clears the burst count and sets a_burst to 2.
//   No clearing pass is needed. a_burst sits at byte address 0 of the APB
//   port; write it only while no request is outstanding.
module two_queue_weighted_server (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         start,
  input  tqws_pkg::in_t                req_i,
  output logic                         busy,
  output logic                         done_o,
  output tqws_pkg::out_t               res_o,
  input  logic                         psel,
  input  logic                         penable,
  input  logic                         pwrite,
  input  logic [tqws_pkg::ApbAw-1:0]   paddr,
  input  logic [tqws_pkg::ApbDw-1:0]   pwdata,
  output logic [tqws_pkg::ApbDw-1:0]   prdata,
  output logic                         pready
);

  logic [tqws_pkg::BurstW-1:0] a_burst_q, a_burst_d;
  logic                        sel_a_burst;
  tqws_pkg::cmd_t              cmd;
  tqws_pkg::stat_t             stat;

  assign pready      = 1'b1;
  assign sel_a_burst = (paddr[2] == tqws_pkg::REG_A_BURST);

  always_comb begin
    a_burst_d = a_burst_q;
    if (psel && penable && pwrite && sel_a_burst) begin
      a_burst_d = pwdata[tqws_pkg::BurstW-1:0];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      a_burst_q <= tqws_pkg::BurstReset;
    end else begin
      a_burst_q <= a_burst_d;
    end
  end

  assign prdata = sel_a_burst ? tqws_pkg::ApbDw'(a_burst_q) : '0;

  tqws_ctrl u_ctrl (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (start),
    .stat_i  (stat),
    .cmd_o   (cmd),
    .busy_o  (busy)
  );

  tqws_dp u_dp (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .in_i      (req_i),
    .a_burst_i (a_burst_q),
    .cmd_i     (cmd),
    .stat_o    (stat),
    .done_o    (done_o),
    .res_o     (res_o)
  );

endmodule

>>> src/tqws_checker.sv
// Port-level checker for the two-queue weighted server, with its bind.
module tqws_checker (
  input logic           clk_i,
  input logic           rst_ni,
  input logic           start,
  input tqws_pkg::in_t  req_i,
  input logic           busy,
  input logic           done_o,
  input tqws_pkg::out_t res_o
);

  // nothing served: id and source are zero
  a_empty_serve: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o && !res_o.served_valid |-> res_o.served_id == '0 && !res_o.served_from_b)
    else $error("empty result carries id or source");

  // a dropped push never reports a served id
  a_drop_excl: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o && res_o.push_dropped |-> !res_o.served_valid)
    else $error("dropped push reports a served id");

  // queue A holds odd ids, queue B even ids
  a_parity: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o && res_o.served_valid |-> res_o.served_id[0] == !res_o.served_from_b)
    else $error("served id parity does not match its queue");

  // a serve transfer raises busy and then returns a result
  a_serve_seq: assert property (@(posedge clk_i) disable iff (!rst_ni)
    start && !busy && req_i.req_type == tqws_pkg::REQ_SERVE |=> busy ##1 done_o)
    else $error("serve transfer did not complete in sequence");

endmodule

bind two_queue_weighted_server tqws_checker u_tqws_checker (
  .clk_i  (clk_i),
  .rst_ni (rst_ni),
  .start  (start),
  .req_i  (req_i),
  .busy   (busy),
  .done_o (done_o),
  .res_o  (res_o)
);

>>> test/tb_two_queue_weighted_server.sv
// Self-checking testbench for the two-queue weighted server: directed and random requests.
`timescale 1ns / 100ps

module tb_two_queue_weighted_server;
  import tqws_pkg::*;

  localparam int CycleLimit   = 200000;
  localparam int PhaseCount   = 9;
  localparam int PhaseItems   = 200;
  localparam int RandomBurst  = 0;
  localparam int DirectedRows = 21;

  typedef struct packed {
    in_t  stim;
    logic typed;
    out_t want;
  } step_row_t;

  logic              clk = 1'b0;
  logic              rst_ni = 1'b0;
  logic              start = 1'b0;
  in_t               req = '0;
  logic              busy;
  logic              done;
  out_t              res;
  logic              psel = 1'b0;
  logic              penable = 1'b0;
  logic              pwrite = 1'b0;
  logic [ApbAw-1:0]  paddr = '0;
  logic [ApbDw-1:0]  pwdata = '0;
  logic [ApbDw-1:0]  prdata;
  logic              pready;

  logic [IdW-1:0]    odd_ids[$];
  logic [IdW-1:0]    even_ids[$];
  logic [BurstW-1:0] a_run = '0;
  logic [BurstW-1:0] burst_limit = BurstReset;
  out_t              pending[$];
  out_t              want;

  int errors = 0;
  int n_push = 0, n_drop = 0, n_serve = 0, n_from_a = 0, n_from_b = 0, n_empty = 0;

  // typed rows assume a_burst at its reset value
  step_row_t directed [DirectedRows] = '{
    '{'{REQ_SERVE, 16'h0000}, 1'b1, '{1'b0, 16'h0000, 1'b0, 1'b0, 7'd0, 7'd0}},
    '{'{REQ_PUSH,  16'hFFFF}, 1'b1, '{1'b0, 16'h0000, 1'b0, 1'b0, 7'd1, 7'd0}},
    '{'{REQ_PUSH,  16'h0000}, 1'b1, '{1'b0, 16'h0000, 1'b0, 1'b0, 7'd1, 7'd1}},
    '{'{REQ_PUSH,  16'h0001}, 1'b1, '{1'b0, 16'h0000, 1'b0, 1'b0, 7'd2, 7'd1}},
    '{'{REQ_PUSH,  16'hFFFE}, 1'b1, '{1'b0, 16'h0000, 1'b0, 1'b0, 7'd2, 7'd2}},
    '{'{REQ_SERVE, 16'hABCD}, 1'b0, '0},
    '{'{REQ_SERVE, 16'h0000}, 1'b0, '0},
    '{'{REQ_SERVE, 16'h5555}, 1'b0, '0},
    '{'{REQ_SERVE, 16'h0000}, 1'b0, '0},
    '{'{REQ_SERVE, 16'hFFFF}, 1'b1, '{1'b0, 16'h0000, 1'b0, 1'b0, 7'd0, 7'd0}},
    '{'{REQ_PUSH,  16'h0003}, 1'b0, '0},
    '{'{REQ_PUSH,  16'h0005}, 1'b0, '0},
    '{'{REQ_PUSH,  16'h0007}, 1'b0, '0},
    '{'{REQ_PUSH,  16'h0009}, 1'b0, '0},
    '{'{REQ_SERVE, 16'h0000}, 1'b0, '0},
    '{'{REQ_SERVE, 16'h0000}, 1'b0, '0},
    '{'{REQ_SERVE, 16'h0000}, 1'b0, '0},
    '{'{REQ_PUSH,  16'h0002}, 1'b0, '0},
    '{'{REQ_SERVE, 16'h0000}, 1'b0, '0},
    '{'{REQ_SERVE, 16'h0000}, 1'b0, '0},
    '{'{REQ_SERVE, 16'h8000}, 1'b1, '{1'b0, 16'h0000, 1'b0, 1'b0, 7'd0, 7'd0}}
  };

  int burst_plan [PhaseCount] = '{2, 1, 15, 15, 1, RandomBurst, RandomBurst, RandomBurst, 2};
  int idle_plan  [PhaseCount] = '{0, 48, 0, 9, 48, 0, 9, 48, 0};
  int push_plan  [PhaseCount] = '{50, 75, 30, 85, 20, 60, 50, 90, 10};

  two_queue_weighted_server dut (
    .clk_i   (clk),
    .rst_ni  (rst_ni),
    .start   (start),
    .req_i   (req),
    .busy    (busy),
    .done_o  (done),
    .res_o   (res),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready)
  );

  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  task automatic report(input string what, input int got, input int exp_val);
    $display("MISMATCH %s: got %0d (0x%0h), expected %0d (0x%0h)", what, got, got,
             exp_val, exp_val);
    errors++;
  endtask

  // files pushes by parity; a serve takes up to burst_limit odd ids, then one even
  task automatic serve_next(input in_t it, output out_t r);
    logic take_odd;
    logic take_even;
    take_odd  = 1'b0;
    take_even = 1'b0;
    r = '0;
    if (it.req_type == REQ_PUSH) begin
      n_push++;
      if (it.customer_id[0]) begin
        if (odd_ids.size() >= Depth) r.push_dropped = 1'b1;
        else odd_ids.push_back(it.customer_id);
      end else begin
        if (even_ids.size() >= Depth) r.push_dropped = 1'b1;
        else even_ids.push_back(it.customer_id);
      end
      if (r.push_dropped) n_drop++;
    end else begin
      n_serve++;
      if (a_run < burst_limit) begin
        if (odd_ids.size() != 0) begin
          take_odd = 1'b1;
          a_run    = a_run + 1'b1;
        end else if (even_ids.size() != 0) begin
          take_even = 1'b1;
          a_run     = '0;
        end
      end else begin
        if (even_ids.size() != 0) begin
          take_even = 1'b1;
          a_run     = '0;
        end else if (odd_ids.size() != 0) begin
          take_odd = 1'b1;
          a_run    = BurstW'(1);
        end
      end
      if (take_odd) begin
        r.served_valid = 1'b1;
        r.served_id    = odd_ids.pop_front();
        n_from_a++;
      end else if (take_even) begin
        r.served_valid  = 1'b1;
        r.served_from_b = 1'b1;
        r.served_id     = even_ids.pop_front();
        n_from_b++;
      end else begin
        n_empty++;
      end
    end
    r.count_a = OutCntW'(odd_ids.size());
    r.count_b = OutCntW'(even_ids.size());
  endtask

  task automatic send(input in_t it, input int idle_pct, input logic use_typed,
                      input out_t typed);
    out_t r;
    while ($urandom_range(99) < idle_pct) begin
      start <= 1'b0;
      @(posedge clk);
    end
    start <= 1'b1;
    req   <= it;
    @(posedge clk);
    while (busy) @(posedge clk);
    serve_next(it, r);
    pending.push_back(use_typed ? typed : r);
  endtask

  task automatic drain;
    start <= 1'b0;
    while (pending.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  task automatic apb_access(input logic wr, input logic [ApbDw-1:0] wdata,
                            output logic [ApbDw-1:0] rdata);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= wr;
    paddr   <= {REG_A_BURST, 2'b00};
    pwdata  <= wdata;
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    while (!pready) @(posedge clk);
    rdata = prdata;
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    @(posedge clk);
  endtask

  task automatic set_burst(input int value);
    logic [ApbDw-1:0] rd;
    drain();
    apb_access(1'b1, ApbDw'(value), rd);
    burst_limit = BurstW'(value);
    apb_access(1'b0, '0, rd);
    if (rd[BurstW-1:0] != burst_limit) report("a_burst readback", rd, value);
  endtask

  always @(posedge clk) begin
    if (rst_ni && done) begin
      if (pending.size() == 0) begin
        report("result with no request outstanding", res.served_id, 0);
      end else begin
        want = pending.pop_front();
        if (res.served_valid !== want.served_valid)
          report("served_valid", res.served_valid, want.served_valid);
        if (res.served_id !== want.served_id)
          report("served_id", res.served_id, want.served_id);
        if (res.served_from_b !== want.served_from_b)
          report("served_from_b", res.served_from_b, want.served_from_b);
        if (res.push_dropped !== want.push_dropped)
          report("push_dropped", res.push_dropped, want.push_dropped);
        if (res.count_a !== want.count_a) report("count_a", res.count_a, want.count_a);
        if (res.count_b !== want.count_b) report("count_b", res.count_b, want.count_b);
      end
    end
  end

  initial begin
    repeat (CycleLimit) @(posedge clk);
    $display("timeout after %0d cycles", CycleLimit);
    $display("two_queue_weighted_server verification failed");
    $finish;
  end

  initial begin
    logic [ApbDw-1:0] rd;
    in_t              it;
    int               burst;
    repeat (10) @(posedge clk);
    rst_ni <= 1'b1;
    @(posedge clk);

    apb_access(1'b0, '0, rd);
    if (rd[BurstW-1:0] != BurstReset) report("a_burst after reset", rd, BurstReset);

    foreach (directed[k]) send(directed[k].stim, 0, directed[k].typed, directed[k].want);

    for (int ph = 0; ph < PhaseCount; ph++) begin
      burst = (burst_plan[ph] == RandomBurst) ? $urandom_range(15, 1) : burst_plan[ph];
      set_burst(burst);
      for (int i = 0; i < PhaseItems; i++) begin
        if (i == PhaseItems / 2) drain();
        it.req_type    = ($urandom_range(99) < push_plan[ph]) ? REQ_PUSH : REQ_SERVE;
        it.customer_id = IdW'($urandom);
        if ($urandom_range(15) == 0) begin
          case ($urandom_range(3))
            0: it.customer_id = 16'h0000;
            1: it.customer_id = 16'h0001;
            2: it.customer_id = 16'hFFFE;
            default: it.customer_id = 16'hFFFF;
          endcase
        end
        send(it, idle_plan[ph], 1'b0, '0);
      end
    end

    drain();
    repeat (10) @(posedge clk);
    $display("ran %0d pushes (%0d dropped on a full queue) and %0d serves", n_push, n_drop,
             n_serve);
    $display("served %0d odd, %0d even, %0d with both queues empty; a_burst 1..15, gaps 0-48%%",
             n_from_a, n_from_b, n_empty);
    if (errors == 0) begin
      $display("two_queue_weighted_server verification clean");
    end else begin
      $display("two_queue_weighted_server verification failed");
    end
    $finish;
  end

endmodule

>>> filelist.f
src/tqws_pkg.sv
src/tqws_ram.sv
src/tqws_ctrl.sv
src/tqws_dp.sv
src/two_queue_weighted_server.sv
src/tqws_checker.sv
test/tb_two_queue_weighted_server.sv
